// ===== hdl/slird_pkg.sv =====
// Shared types and codes for the array list block.
`timescale 1ns / 1ps

package slird_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_POS   = 2'd1;
  localparam logic [1:0] STATUS_BAD_RANGE = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PUT,
    ST_SCAN,
    ST_FETCH,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/slird_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module slird_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/sequential_list_insert_range_delete.sv =====
// Ordered array list with run insert, range delete, read and clear.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   input   | in_valid, in_ready  | mode, position, value, run_last,
//           |                     | lower_bound, upper_bound
//   output  | out_valid, out_ready| status, list_length, removed_count,
//           |                     | element_value
//
// The list lives in one RAM with a single write port and a registered read port.
// An insert moves the entries from the insert index on up by one and then writes
// the value; a range delete scans every entry and packs the kept ones down; a
// read fetches one entry; a clear or a rejected item goes straight to the result.
// Reset empties the list at once; no RAM entry is cleared. One item is worked on
// at a time; a new item is accepted while the previous result waits.
`timescale 1ns / 1ps

module sequential_list_insert_range_delete #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [6:0]         position,
  input  logic signed [31:0] value,
  input  logic               run_last,
  input  logic signed [31:0] lower_bound,
  input  logic signed [31:0] upper_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [6:0]         list_length,
  output logic [6:0]         removed_count,
  output logic signed [31:0] element_value
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  slird_pkg::state_t state, state_next;

  logic [CW-1:0]      count;
  logic [CW-1:0]      cursor;
  logic               in_run;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      tgt;
  logic [CW-1:0]      kept;
  logic [CW-1:0]      removed;
  logic               pend;
  logic [AW-1:0]      pend_addr;
  logic signed [31:0] val_q;
  logic signed [31:0] lo_q;
  logic signed [31:0] hi_q;
  logic [1:0]         res_status;
  logic [CW-1:0]      res_removed;
  logic [31:0]        res_element;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  logic               accept;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      cnt_x;
  logic               ins_bad_pos;
  logic               rd_bad_pos;
  logic [CW-1:0]      cursor_eff;
  logic               ins_full;
  logic               in_range;
  logic               out_free;

  slird_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready    = (state == slird_pkg::ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign pos_x       = XW'(position);
  assign cnt_x       = XW'(count);
  assign ins_bad_pos = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
  assign rd_bad_pos  = (pos_x == '0) || (pos_x > cnt_x);
  assign cursor_eff  = in_run ? cursor : CW'(pos_x - XW'(1));
  assign ins_full    = (count == CW'(CAPACITY)) || (cursor_eff > count);
  assign in_range    = ($signed(rd_data) >= lo_q) && ($signed(rd_data) <= hi_q);
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      slird_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            slird_pkg::MODE_INSERT: begin
              if (!in_run && ins_bad_pos) begin
                state_next = slird_pkg::ST_EMIT;
              end else if (ins_full) begin
                state_next = slird_pkg::ST_EMIT;
              end else begin
                state_next = slird_pkg::ST_SHIFT;
              end
            end
            slird_pkg::MODE_DELETE: begin
              state_next = (lower_bound > upper_bound) ? slird_pkg::ST_EMIT
                                                       : slird_pkg::ST_SCAN;
            end
            slird_pkg::MODE_READ: begin
              state_next = rd_bad_pos ? slird_pkg::ST_EMIT : slird_pkg::ST_FETCH;
            end
            slird_pkg::MODE_CLEAR: begin
              state_next = slird_pkg::ST_EMIT;
            end
            default: state_next = slird_pkg::ST_EMIT;
          endcase
        end
      end
      slird_pkg::ST_SHIFT: begin
        if (ptr == tgt) begin
          state_next = slird_pkg::ST_PUT;
        end
      end
      slird_pkg::ST_PUT: begin
        state_next = slird_pkg::ST_EMIT;
      end
      slird_pkg::ST_SCAN: begin
        if (ptr == count && !pend) begin
          state_next = slird_pkg::ST_EMIT;
        end
      end
      slird_pkg::ST_FETCH: begin
        state_next = slird_pkg::ST_EMIT;
      end
      slird_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = slird_pkg::ST_IDLE;
        end
      end
      default: state_next = slird_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    rd_addr = AW'(pos_x - XW'(1));
    unique case (state)
      slird_pkg::ST_SHIFT: begin
        rd_addr = AW'(ptr - CW'(1));
        wr_en   = pend;
      end
      slird_pkg::ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(tgt);
        wr_data = val_q;
      end
      slird_pkg::ST_SCAN: begin
        rd_addr = AW'(ptr);
        wr_en   = pend && !in_range;
        wr_addr = AW'(kept);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slird_pkg::ST_IDLE;
      count     <= '0;
      cursor    <= '0;
      in_run    <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != slird_pkg::ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        slird_pkg::ST_IDLE: begin
          if (accept) begin
            val_q       <= value;
            lo_q        <= lower_bound;
            hi_q        <= upper_bound;
            res_removed <= '0;
            res_element <= '0;
            pend        <= 1'b0;
            unique case (mode)
              slird_pkg::MODE_INSERT: begin
                if (!in_run && ins_bad_pos) begin
                  res_status <= slird_pkg::STATUS_BAD_POS;
                end else if (ins_full) begin
                  res_status <= slird_pkg::STATUS_FULL;
                  cursor     <= cursor_eff;
                  if (run_last) begin
                    in_run <= 1'b0;
                  end
                end else begin
                  res_status <= slird_pkg::STATUS_OK;
                  ptr        <= count;
                  tgt        <= cursor_eff;
                  cursor     <= cursor_eff + CW'(1);
                  in_run     <= !run_last;
                end
              end
              slird_pkg::MODE_DELETE: begin
                in_run  <= 1'b0;
                ptr     <= '0;
                kept    <= '0;
                removed <= '0;
                if (lower_bound > upper_bound) begin
                  res_status <= slird_pkg::STATUS_BAD_RANGE;
                end else begin
                  res_status <= slird_pkg::STATUS_OK;
                end
              end
              slird_pkg::MODE_READ: begin
                in_run <= 1'b0;
                if (rd_bad_pos) begin
                  res_status <= slird_pkg::STATUS_BAD_POS;
                end else begin
                  res_status <= slird_pkg::STATUS_OK;
                end
              end
              slird_pkg::MODE_CLEAR: begin
                res_status <= slird_pkg::STATUS_OK;
                in_run     <= 1'b0;
                count      <= '0;
                cursor     <= '0;
              end
              default: begin
                res_status <= slird_pkg::STATUS_OK;
              end
            endcase
          end
        end
        slird_pkg::ST_SHIFT: begin
          if (ptr > tgt) begin
            pend      <= 1'b1;
            pend_addr <= AW'(ptr);
            ptr       <= ptr - CW'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        slird_pkg::ST_PUT: begin
          count <= count + CW'(1);
        end
        slird_pkg::ST_SCAN: begin
          if (ptr < count) begin
            pend <= 1'b1;
            ptr  <= ptr + CW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (in_range) begin
              removed <= removed + CW'(1);
            end else begin
              kept <= kept + CW'(1);
            end
          end
          if (ptr == count && !pend) begin
            count       <= kept;
            res_removed <= removed;
          end
        end
        slird_pkg::ST_FETCH: begin
          res_element <= rd_data;
        end
        slird_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            list_length   <= 7'(count);
            removed_count <= 7'(res_removed);
            element_value <= res_element;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== dv/sequential_list_insert_range_delete_test.sv =====
// Self-checking testbench for the array list block with run insert, range delete, read and clear.
`timescale 1ns / 1ps

module sequential_list_insert_range_delete_test;

  localparam int LIST_CAPACITY = 64;
  localparam int MAX_IDLE = 18;
  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         length;
    logic [6:0]         removed;
    logic signed [31:0] element;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         mode = slird_pkg::MODE_CLEAR;
  logic [6:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               run_last = 1'b0;
  logic signed [31:0] lower_bound = '0;
  logic signed [31:0] upper_bound = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [6:0]         list_length;
  logic [6:0]         removed_count;
  logic signed [31:0] element_value;

  logic signed [31:0] shadow_list [LIST_CAPACITY];
  int                 shadow_len = 0;
  int                 shadow_cursor = 0;
  bit                 shadow_in_run = 1'b0;
  list_result_t       list_results_due [$];

  int items_sent = 0;
  int mismatch_count = 0;
  int send_gap_max = MAX_IDLE;
  int recv_stall_max = MAX_IDLE;
  int stall_left = 0;
  int idle_cycles = 0;

  sequential_list_insert_range_delete #(
    .CAPACITY(LIST_CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .position(position),
    .value(value),
    .run_last(run_last),
    .lower_bound(lower_bound),
    .upper_bound(upper_bound),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .list_length(list_length),
    .removed_count(removed_count),
    .element_value(element_value)
  );

  always #10 clk = ~clk;

  function automatic list_result_t apply_list_op(input logic [1:0] op, input logic [6:0] pos,
                                                 input logic signed [31:0] val, input logic last,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    list_result_t r;
    int k;
    int kept;
    int gone;
    r = '0;
    if (op == slird_pkg::MODE_INSERT) begin
      if (!shadow_in_run && (int'(pos) < 1 || int'(pos) > shadow_len + 1)) begin
        r.status = slird_pkg::STATUS_BAD_POS;
      end else begin
        if (!shadow_in_run) begin
          shadow_cursor = int'(pos) - 1;
        end
        if (shadow_len >= LIST_CAPACITY || shadow_cursor > shadow_len) begin
          r.status = slird_pkg::STATUS_FULL;
          if (last) begin
            shadow_in_run = 1'b0;
          end
        end else begin
          for (k = shadow_len; k > shadow_cursor; k--) begin
            shadow_list[k] = shadow_list[k - 1];
          end
          shadow_list[shadow_cursor] = val;
          shadow_cursor++;
          shadow_len++;
          shadow_in_run = !last;
          r.status = slird_pkg::STATUS_OK;
        end
      end
    end else begin
      shadow_in_run = 1'b0;
      if (op == slird_pkg::MODE_DELETE) begin
        if (lo > hi) begin
          r.status = slird_pkg::STATUS_BAD_RANGE;
        end else begin
          kept = 0;
          gone = 0;
          for (k = 0; k < shadow_len; k++) begin
            if (shadow_list[k] >= lo && shadow_list[k] <= hi) begin
              gone++;
            end else begin
              shadow_list[kept] = shadow_list[k];
              kept++;
            end
          end
          shadow_len = kept;
          r.status = slird_pkg::STATUS_OK;
          r.removed = gone[6:0];
        end
      end else if (op == slird_pkg::MODE_READ) begin
        if (int'(pos) < 1 || int'(pos) > shadow_len) begin
          r.status = slird_pkg::STATUS_BAD_POS;
        end else begin
          r.status = slird_pkg::STATUS_OK;
          r.element = shadow_list[int'(pos) - 1];
        end
      end else begin
        shadow_len = 0;
        shadow_cursor = 0;
        r.status = slird_pkg::STATUS_OK;
      end
    end
    r.length = shadow_len[6:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_element();
    case ($urandom_range(0, 5))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3: return int'($urandom_range(0, 40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic send_list_op(input logic [1:0] op, input int pos,
                              input logic signed [31:0] val, input int last,
                              input logic signed [31:0] lo, input logic signed [31:0] hi);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    list_results_due.push_back(apply_list_op(op, pos[6:0], val, last[0], lo, hi));
    in_valid <= 1'b1;
    mode <= op;
    position <= pos[6:0];
    value <= val;
    run_last <= last[0];
    lower_bound <= lo;
    upper_bound <= hi;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (list_results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : recv_pacing
    int draw;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      draw = $urandom_range(0, recv_stall_max);
      out_ready <= (draw == 0);
      stall_left <= draw;
    end else if (!out_ready) begin
      if (stall_left <= 1) begin
        out_ready <= 1'b1;
      end
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (list_results_due.size() == 0) begin
        report_mismatch("unexpected result, status", longint'(status), 0);
      end else begin
        want = list_results_due.pop_front();
        if (status !== want.status) begin
          report_mismatch("status", longint'(status), longint'(want.status));
        end
        if (list_length !== want.length) begin
          report_mismatch("list_length", longint'(list_length), longint'(want.length));
        end
        if (removed_count !== want.removed) begin
          report_mismatch("removed_count", longint'(removed_count), longint'(want.removed));
        end
        if (element_value !== want.element) begin
          report_mismatch("element_value", longint'(element_value), longint'(want.element));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic test_bad_positions();
    send_list_op(slird_pkg::MODE_READ, 1, 0, 0, 0, 0);
    send_list_op(slird_pkg::MODE_DELETE, 0, 0, 0, -5, 5);
    send_list_op(slird_pkg::MODE_INSERT, 0, 7, 1, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, 2, 7, 1, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, 127, 7, 0, 0, 0);
  endtask

  task automatic test_run_insert_and_read();
    int k;
    send_list_op(slird_pkg::MODE_INSERT, 1, VAL_MIN, 0, VAL_MAX, VAL_MIN);
    send_list_op(slird_pkg::MODE_INSERT, 127, VAL_MAX, 0, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, 0, 0, 1, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, 2, -1, 1, 0, 0);
    for (k = 1; k <= 5; k++) begin
      send_list_op(slird_pkg::MODE_READ, k, 0, 0, 0, 0);
    end
    send_list_op(slird_pkg::MODE_READ, 127, 0, 0, 0, 0);
  endtask

  task automatic test_range_delete();
    send_list_op(slird_pkg::MODE_DELETE, 0, 0, 0, 1, 0);
    send_list_op(slird_pkg::MODE_DELETE, 0, 0, 0, VAL_MAX, VAL_MIN);
    send_list_op(slird_pkg::MODE_DELETE, 0, 0, 0, -1, 0);
    send_list_op(slird_pkg::MODE_READ, 2, 0, 0, 0, 0);
    send_list_op(slird_pkg::MODE_DELETE, 0, 0, 0, VAL_MIN, VAL_MAX);
  endtask

  task automatic test_run_interrupt_and_clear();
    send_list_op(slird_pkg::MODE_INSERT, 1, 5, 0, 0, 0);
    send_list_op(slird_pkg::MODE_READ, 1, 0, 0, 0, 0);
    // The read closed the run, so this insert is a run start with a bad position.
    send_list_op(slird_pkg::MODE_INSERT, 127, 6, 0, 0, 0);
    send_list_op(slird_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
    send_list_op(slird_pkg::MODE_READ, 1, 0, 0, 0, 0);
  endtask

  task automatic test_full_list();
    int k;
    send_list_op(slird_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
    for (k = 0; k < LIST_CAPACITY - 2; k++) begin
      send_list_op(slird_pkg::MODE_INSERT, (k == 0) ? 1 : $urandom_range(0, 127),
                   rand_element(), int'(k == LIST_CAPACITY - 3), $urandom, $urandom);
    end
    // A run opened in the middle fills the list and then overflows twice.
    send_list_op(slird_pkg::MODE_INSERT, 10, rand_element(), 0, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, 0, rand_element(), 0, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, 0, rand_element(), 0, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, 0, rand_element(), 1, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, LIST_CAPACITY + 2, 1, 1, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, LIST_CAPACITY + 1, 1, 1, 0, 0);
    send_list_op(slird_pkg::MODE_INSERT, 1, 1, 0, 0, 0);
    for (k = 1; k <= LIST_CAPACITY + 1; k++) begin
      send_list_op(slird_pkg::MODE_READ, k, 0, 0, 0, 0);
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int item_goal);
    int first_item;
    int pick;
    int run_len;
    int start_pos;
    int k;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    first_item = items_sent;
    while (items_sent - first_item < item_goal) begin
      if ($urandom_range(0, 15) == 0) begin
        send_gap_max = (send_gap_max == 0) ? MAX_IDLE : 0;
      end
      if ($urandom_range(0, 15) == 0) begin
        recv_stall_max = (recv_stall_max == 0) ? MAX_IDLE : 0;
      end
      if ($urandom_range(0, 39) == 0) begin
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        run_len = $urandom_range(1, 8);
        start_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, shadow_len + 1);
        for (k = 0; k < run_len; k++) begin
          // Now and then the run is left open for the next item to close or extend.
          send_list_op(slird_pkg::MODE_INSERT, (k == 0) ? start_pos : $urandom_range(0, 127),
                       rand_element(),
                       int'((k == run_len - 1) && ($urandom_range(0, 9) != 0)),
                       $urandom, $urandom);
        end
      end else if (pick < 65) begin
        case ($urandom_range(0, 9))
          7: begin
            lo = $urandom;
            hi = $urandom;
          end
          8: begin
            lo = VAL_MIN + $urandom_range(0, 3);
            hi = VAL_MAX - $urandom_range(0, 3);
          end
          9: begin
            hi = rand_element();
            lo = (hi == VAL_MAX) ? VAL_MAX : hi + $urandom_range(1, 8);
            hi = (hi == VAL_MAX) ? VAL_MAX - 1 : hi;
          end
          default: begin
            lo = int'($urandom_range(0, 40)) - 20;
            hi = lo + $urandom_range(0, 10);
          end
        endcase
        send_list_op(slird_pkg::MODE_DELETE, $urandom_range(0, 127), $urandom,
                     $urandom_range(0, 1), lo, hi);
      end else if (pick < 85) begin
        start_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, (shadow_len > 0) ? shadow_len : 1);
        send_list_op(slird_pkg::MODE_READ, start_pos, $urandom, $urandom_range(0, 1),
                     $urandom, $urandom);
      end else if (pick < 90) begin
        send_list_op(slird_pkg::MODE_CLEAR, $urandom_range(0, 127), $urandom,
                     $urandom_range(0, 1), $urandom, $urandom);
      end else begin
        send_list_op(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom,
                     $urandom_range(0, 1), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_bad_positions();
    test_run_insert_and_read();
    test_range_delete();
    test_run_interrupt_and_clear();
    test_full_list();
    test_random_traffic(1090);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/slird_pkg.sv
hdl/slird_ram.sv
hdl/sequential_list_insert_range_delete.sv
dv/sequential_list_insert_range_delete_test.sv
